### src/cdm_pkg.sv
// Package: widths, types, mode codes and control struct for the channel downmix mapper.
package cdm_pkg;

  localparam int LANES     = 8;
  localparam int SAMPLE_W  = 24;
  localparam int OUT_W     = 26;
  localparam int SUM_W     = 26;
  localparam int ACC_W     = 28;
  localparam int PROD_W    = SUM_W + 16;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ATT_LANES = 6;
  localparam int ATT_SIDE  = 3;
  localparam int ATT_SHIFT = 15;

  localparam logic [14:0]      ATT_GAIN     = 15'd23170;
  localparam logic [CNT_W-1:0] MAX_CHANNELS = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_CHANNELS = 2'd1;

  localparam logic [1:0] MODE_COPY     = 2'd0;
  localparam logic [1:0] MODE_MONO_SRC = 2'd1;
  localparam logic [1:0] MODE_FOLD     = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] samp_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [OUT_W-1:0]    outs_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LANES-1:0] copy_mask;
    logic [LANES-1:0] out_mask;
    logic             mono_sink;
    logic [CNT_W-1:0] src_cnt;
  } ctrl_t;

  function automatic sum_t sx(input samp_t s);
    return SUM_W'(s);
  endfunction

endpackage

### src/cdm_if.sv
// Interfaces: input frame channel and mapped frame channel.
interface cdm_in_if import cdm_pkg::*;;
  logic  valid;
  logic  ready;
  samp_t sample_0;
  samp_t sample_1;
  samp_t sample_2;
  samp_t sample_3;
  samp_t sample_4;
  samp_t sample_5;
  samp_t sample_6;
  samp_t sample_7;
  logic  frame_last;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, sample_6, sample_7, frame_last, input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, sample_6, sample_7, frame_last, output ready);
endinterface

interface cdm_out_if import cdm_pkg::*;;
  logic  valid;
  logic  ready;
  outs_t out_0;
  outs_t out_1;
  outs_t out_2;
  outs_t out_3;
  outs_t out_4;
  outs_t out_5;
  outs_t out_6;
  outs_t out_7;
  logic  out_last;

  modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                  out_7, out_last, input ready);
  modport sink   (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                  out_7, out_last, output ready);
endinterface

### src/cdm_att_lane.sv
// Attenuation lane: registered round-to-nearest multiply by 0.7071 (Q1.15).
module cdm_att_lane import cdm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sum_t  din,
  output outs_t att_r
);

  localparam logic signed [PROD_W-1:0] GAIN_EXT = PROD_W'($signed({1'b0, ATT_GAIN}));
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (ATT_SHIFT - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  outs_t                    att_nxt;

  always_comb begin
    prod    = PROD_W'(din) * GAIN_EXT;
    rnd     = (prod + RND_HALF) >>> ATT_SHIFT;
    att_nxt = rnd[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      att_r <= att_nxt;
    end
  end

endmodule

### src/cdm_merge.sv
// Merge stage: combines lane results with the passed samples into the output register.
module cdm_merge import cdm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ctrl_t ctrl,
  input  samp_t samp [LANES],
  input  outs_t att  [ATT_LANES],
  input  logic  last,
  output outs_t out_r [LANES],
  output logic  last_r
);

  logic signed [ACC_W-1:0] left;
  logic signed [ACC_W-1:0] right;
  logic signed [ACC_W-1:0] both;
  outs_t                   mono;
  outs_t                   out_nxt [LANES];

  always_comb begin
    left  = ACC_W'(samp[0]) + ACC_W'(att[0]) + ACC_W'(att[1]) + ACC_W'(att[2]);
    right = ACC_W'(samp[1]) + ACC_W'(att[3]) + ACC_W'(att[4]) + ACC_W'(att[5]);
    both  = (left + right) >>> 1;
    mono  = both[OUT_W-1:0];
    for (int i = 0; i < LANES; i++) begin
      out_nxt[i] = '0;
      unique case (ctrl.mode)
        MODE_COPY: begin
          if (ctrl.copy_mask[i]) out_nxt[i] = OUT_W'(samp[i]);
        end
        MODE_MONO_SRC: begin
          if (i == 0 || (i == 1 && !ctrl.mono_sink)) out_nxt[i] = OUT_W'(samp[0]);
        end
        MODE_FOLD: begin
          if (i == 0) out_nxt[i] = ctrl.mono_sink ? mono : left[OUT_W-1:0];
          else if (i == 1 && !ctrl.mono_sink) out_nxt[i] = right[OUT_W-1:0];
        end
        default: out_nxt[i] = '0;
      endcase
      if (!ctrl.out_mask[i]) out_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r  <= out_nxt;
      last_r <= last;
    end
  end

endmodule

### src/channel_downmix_mapper_top.sv
// Top level: config registers, lane input select, attenuation lanes and merge stage.
// Maps one frame of up to eight Q1.23 samples per cycle onto the configured sink layout.
// The pipeline has the attenuation multiply lanes, then the merge/output register;
// a new frame is accepted every cycle while the output side keeps taking beats, and
// the input keeps flowing while a finished beat waits as long as the lane stage is free.
// src_channels and dst_channels reset to 2 and are written through cfg_we/cfg_idx/cfg_wdata
// by the user only while no beat is in flight (not enforced); 0 acts as 1 and values above 8 act as 8.
module channel_downmix_mapper_top import cdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CNT_W-1:0]     cfg_wdata,
  cdm_in_if.sink               in_ch,
  cdm_out_if.source            out_ch
);

  logic [CNT_W-1:0] src_cnt_r;
  logic [CNT_W-1:0] dst_cnt_r;
  logic [CNT_W-1:0] sc_eff;
  logic [CNT_W-1:0] dc_eff;
  logic [CNT_W-1:0] shared_cnt;
  ctrl_t            ctrl;

  logic  v1_r, v1_nxt;
  logic  v2_r, v2_nxt;
  logic  adv1;
  logic  in_ready;
  samp_t samp_in [LANES];
  samp_t samp1_r [LANES];
  logic  last1_r;
  sum_t  lane_in [ATT_LANES];
  outs_t att     [ATT_LANES];
  outs_t out_r   [LANES];
  logic  last2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= 4'd2;
      dst_cnt_r <= 4'd2;
    end else if (cfg_we) begin
      if (cfg_idx == REG_SRC_CHANNELS) src_cnt_r <= cfg_wdata;
      if (cfg_idx == REG_DST_CHANNELS) dst_cnt_r <= cfg_wdata;
    end
  end

  always_comb begin
    sc_eff = (src_cnt_r == '0) ? CNT_W'(1) :
             (src_cnt_r > MAX_CHANNELS) ? MAX_CHANNELS : src_cnt_r;
    dc_eff = (dst_cnt_r == '0) ? CNT_W'(1) :
             (dst_cnt_r > MAX_CHANNELS) ? MAX_CHANNELS : dst_cnt_r;
    shared_cnt = (sc_eff < dc_eff) ? sc_eff : dc_eff;
    ctrl.src_cnt   = sc_eff;
    ctrl.mono_sink = (dc_eff == CNT_W'(1));
    priority if (sc_eff == dc_eff) ctrl.mode = MODE_COPY;
    else if (sc_eff == CNT_W'(1))  ctrl.mode = MODE_MONO_SRC;
    else if (dc_eff <= CNT_W'(2))  ctrl.mode = MODE_FOLD;
    else                           ctrl.mode = MODE_COPY;
    for (int i = 0; i < LANES; i++) begin
      ctrl.copy_mask[i] = (CNT_W'(i) < shared_cnt);
      ctrl.out_mask[i]  = (CNT_W'(i) < dc_eff);
    end
  end

  assign adv1     = !v2_r || out_ch.ready;
  assign in_ready = !v1_r || adv1;
  assign in_ch.ready = in_ready;

  always_comb begin
    v1_nxt = in_ready ? in_ch.valid : v1_r;
    v2_nxt = adv1 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  assign samp_in[0] = in_ch.sample_0;
  assign samp_in[1] = in_ch.sample_1;
  assign samp_in[2] = in_ch.sample_2;
  assign samp_in[3] = in_ch.sample_3;
  assign samp_in[4] = in_ch.sample_4;
  assign samp_in[5] = in_ch.sample_5;
  assign samp_in[6] = in_ch.sample_6;
  assign samp_in[7] = in_ch.sample_7;

  // lanes 0..2 feed left, 3..5 feed right
  always_comb begin
    for (int k = 0; k < ATT_LANES; k++) lane_in[k] = '0;
    unique case (ctrl.src_cnt)
      4'd3: begin
        lane_in[0] = sx(samp_in[2]);
        lane_in[3] = sx(samp_in[2]);
      end
      4'd4: begin
        lane_in[0] = sx(samp_in[2]);
        lane_in[3] = sx(samp_in[3]);
      end
      4'd5: begin
        lane_in[0] = sx(samp_in[2]) + sx(samp_in[3]);
        lane_in[3] = sx(samp_in[2]) + sx(samp_in[4]);
      end
      4'd6: begin
        lane_in[0] = sx(samp_in[2]) + sx(samp_in[4]);
        lane_in[3] = sx(samp_in[2]) + sx(samp_in[5]);
      end
      4'd7: begin
        lane_in[0] = sx(samp_in[2]);
        lane_in[1] = sx(samp_in[4]);
        lane_in[2] = sx(samp_in[6]);
        lane_in[3] = sx(samp_in[3]);
        lane_in[4] = sx(samp_in[5]);
      end
      4'd8: begin
        lane_in[0] = sx(samp_in[2]) + sx(samp_in[4]) + sx(samp_in[6]);
        lane_in[3] = sx(samp_in[2]) + sx(samp_in[5]) + sx(samp_in[7]);
      end
      default: begin
        for (int k = 0; k < ATT_LANES; k++) lane_in[k] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      samp1_r <= samp_in;
      last1_r <= in_ch.frame_last;
    end
  end

  for (genvar g = 0; g < ATT_LANES; g++) begin : g_lane
    cdm_att_lane u_lane (
      .clk   (clk),
      .en    (in_ready),
      .din   (lane_in[g]),
      .att_r (att[g])
    );
  end

  cdm_merge u_merge (
    .clk    (clk),
    .en     (adv1),
    .ctrl   (ctrl),
    .samp   (samp1_r),
    .att    (att),
    .last   (last1_r),
    .out_r  (out_r),
    .last_r (last2_r)
  );

  assign out_ch.valid    = v2_r;
  assign out_ch.out_0    = out_r[0];
  assign out_ch.out_1    = out_r[1];
  assign out_ch.out_2    = out_r[2];
  assign out_ch.out_3    = out_r[3];
  assign out_ch.out_4    = out_r[4];
  assign out_ch.out_5    = out_r[5];
  assign out_ch.out_6    = out_r[6];
  assign out_ch.out_7    = out_r[7];
  assign out_ch.out_last = last2_r;

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v2_r |-> in_ready) else $error("input stalled with empty output");

  a_lane_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv1) |=> v2_r) else $error("lane stage beat lost");

  a_mono_sink_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && dc_eff == CNT_W'(1)) |-> (out_r[1] == '0 && out_r[7] == '0))
    else $error("mono sink drives extra channels");

endmodule

### sim/channel_downmix_mapper_top_tb.sv
// Testbench: random and directed frames through the channel downmix mapper, checked per beat.
`timescale 1ns / 100ps

module channel_downmix_mapper_top_tb;
  import cdm_pkg::*;

  typedef struct packed {
    logic                             last;
    logic [LANES-1:0][SAMPLE_W-1:0]   smp;
  } frame_t;

  typedef struct packed {
    logic                             last;
    logic [LANES-1:0][OUT_W-1:0]      ch;
  } mapped_t;

  localparam int RANDOM_FRAMES = 1650;
  localparam int RX_HOLD_CYCLES = 300;
  localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7fffff;
  localparam logic [SAMPLE_W-1:0] S_MIN = 24'h800000;
  localparam logic [SAMPLE_W-1:0] S_TIE = 24'h002000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CNT_W-1:0]     cfg_wdata;

  cdm_in_if  in_ch ();
  cdm_out_if out_ch ();

  channel_downmix_mapper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  frame_t  pending_frames [$];
  mapped_t expected_maps [$];
  logic [CNT_W-1:0] src_reg = 4'd2;
  logic [CNT_W-1:0] dst_reg = 4'd2;
  int errors = 0;
  int tx_idle_pct = 10;
  int rx_idle_pct = 50;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  bit offering = 0;
  mapped_t got_map;
  mapped_t want_map;

  logic [CNT_W-1:0] dir_src [12] = '{4'd2, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6,
                                     4'd7, 4'd8, 4'd8, 4'd0, 4'd4, 4'd15};
  logic [CNT_W-1:0] dir_dst [12] = '{4'd2, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1,
                                     4'd2, 4'd2, 4'd1, 4'd15, 4'd6, 4'd8};

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int eff_cnt(input logic [CNT_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_CHANNELS) return int'(MAX_CHANNELS);
    return int'(r);
  endfunction

  function automatic longint attenuate(input longint s);
    longint p;
    p = s * longint'(ATT_GAIN) + (longint'(1) << (ATT_SHIFT - 1));
    return p >>> ATT_SHIFT;
  endfunction

  function automatic mapped_t map_frame(input frame_t f, input logic [CNT_W-1:0] src_r,
                                        input logic [CNT_W-1:0] dst_r);
    longint s [LANES];
    longint o [LANES];
    longint l;
    longint r;
    samp_t  v;
    int     sc;
    int     dc;
    int     shared;
    mapped_t m;
    sc = eff_cnt(src_r);
    dc = eff_cnt(dst_r);
    for (int i = 0; i < LANES; i++) begin
      v = f.smp[i];
      s[i] = (i < sc) ? longint'(v) : 0;
      o[i] = 0;
    end
    if (sc == dc) begin
      for (int i = 0; i < sc; i++) o[i] = s[i];
    end else if (sc == 1) begin
      o[0] = s[0];
      if (dc >= 2) o[1] = s[0];
    end else if (dc <= 2) begin
      l = s[0];
      r = s[1];
      case (sc)
        3: begin
          l += attenuate(s[2]);
          r += attenuate(s[2]);
        end
        4: begin
          l += attenuate(s[2]);
          r += attenuate(s[3]);
        end
        5: begin
          l += attenuate(s[2] + s[3]);
          r += attenuate(s[2] + s[4]);
        end
        6: begin
          l += attenuate(s[2] + s[4]);
          r += attenuate(s[2] + s[5]);
        end
        8: begin
          l += attenuate(s[2] + s[4] + s[6]);
          r += attenuate(s[2] + s[5] + s[7]);
        end
        default: begin
          for (int i = 2; i < sc; i++) begin
            if (i % 2 == 0) l += attenuate(s[i]);
            else r += attenuate(s[i]);
          end
        end
      endcase
      if (dc == 1) begin
        o[0] = (l + r) >>> 1;
      end else begin
        o[0] = l;
        o[1] = r;
      end
    end else begin
      shared = (sc < dc) ? sc : dc;
      for (int i = 0; i < shared; i++) o[i] = s[i];
    end
    for (int i = 0; i < LANES; i++) m.ch[i] = (i < dc) ? o[i][OUT_W-1:0] : '0;
    m.last = f.last;
    return m;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return ($urandom_range(1) != 0) ? S_TIE : -S_TIE;
      3: return SAMPLE_W'($urandom_range(255)) - 24'd128;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int i = 0; i < LANES; i++) f.smp[i] = rand_sample();
    f.last = 1'($urandom_range(1));
    return f;
  endfunction

  function automatic logic [CNT_W-1:0] rand_src();
    if ($urandom_range(9) == 0) return CNT_W'($urandom_range(15));
    return CNT_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [CNT_W-1:0] rand_dst();
    if ($urandom_range(1) == 0) return CNT_W'($urandom_range(1, 2));
    return rand_src();
  endfunction

  task automatic write_counts(input logic [CNT_W-1:0] src, input logic [CNT_W-1:0] dst);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SRC_CHANNELS;
    cfg_wdata <= src;
    @(negedge clk);
    cfg_idx   <= REG_DST_CHANNELS;
    cfg_wdata <= dst;
    @(negedge clk);
    cfg_we    <= 1'b0;
    src_reg = src;
    dst_reg = dst;
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0 || expected_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input beats: accepted at posedge, next offer at negedge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_maps.push_back(map_frame(pending_frames[0], src_reg, dst_reg));
      pending_frames.pop_front();
      offering = 0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!offering) begin
      if (pending_frames.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_ch.sample_0   <= pending_frames[0].smp[0];
        in_ch.sample_1   <= pending_frames[0].smp[1];
        in_ch.sample_2   <= pending_frames[0].smp[2];
        in_ch.sample_3   <= pending_frames[0].smp[3];
        in_ch.sample_4   <= pending_frames[0].smp[4];
        in_ch.sample_5   <= pending_frames[0].smp[5];
        in_ch.sample_6   <= pending_frames[0].smp[6];
        in_ch.sample_7   <= pending_frames[0].smp[7];
        in_ch.frame_last <= pending_frames[0].last;
        in_ch.valid      <= 1'b1;
        offering = 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = RX_HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_map.ch[0] = out_ch.out_0;
      got_map.ch[1] = out_ch.out_1;
      got_map.ch[2] = out_ch.out_2;
      got_map.ch[3] = out_ch.out_3;
      got_map.ch[4] = out_ch.out_4;
      got_map.ch[5] = out_ch.out_5;
      got_map.ch[6] = out_ch.out_6;
      got_map.ch[7] = out_ch.out_7;
      got_map.last  = out_ch.out_last;
      if (expected_maps.size() == 0) begin
        $display("%0t: beat with nothing expected, expected none, got %h", $time, got_map);
        errors++;
      end else begin
        want_map = expected_maps.pop_front();
        for (int i = 0; i < LANES; i++) begin
          if (got_map.ch[i] !== want_map.ch[i]) begin
            $display("%0t: out_%0d expected %0d got %0d", $time, i,
                     $signed(want_map.ch[i]), $signed(got_map.ch[i]));
            errors++;
          end
        end
        if (got_map.last !== want_map.last) begin
          $display("%0t: out_last expected %0b got %0b", $time, want_map.last, got_map.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("channel_downmix_mapper_top verification failed");
    $finish;
  end

  initial begin
    int     rand_done;
    int     seg_len;
    int     seg_idx;
    frame_t f;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_SRC_CHANNELS;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample_0 = '0;
    in_ch.sample_1 = '0;
    in_ch.sample_2 = '0;
    in_ch.sample_3 = '0;
    in_ch.sample_4 = '0;
    in_ch.sample_5 = '0;
    in_ch.sample_6 = '0;
    in_ch.sample_7 = '0;
    in_ch.frame_last = 1'b0;
    out_ch.ready   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: each listed layout pair, full-scale and rounding-tie frames
    for (int p = 0; p < 12; p++) begin
      if (p != 0) write_counts(dir_src[p], dir_dst[p]);
      for (int i = 0; i < LANES; i++) f.smp[i] = S_MAX;
      f.last = 1'b1;
      pending_frames.push_back(f);
      for (int i = 0; i < LANES; i++)
        f.smp[i] = (i % 3 == 0) ? S_MIN : (i % 3 == 1) ? -S_TIE : S_TIE;
      f.last = 1'b0;
      pending_frames.push_back(f);
      wait_drained();
    end

    rand_done = 0;
    seg_idx = 0;
    while (rand_done < RANDOM_FRAMES) begin
      if (rand_done < RANDOM_FRAMES / 3) begin
        tx_idle_pct = 10;
        rx_idle_pct = 50;
      end else if (rand_done < 2 * RANDOM_FRAMES / 3) begin
        tx_idle_pct = 50;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_counts(rand_src(), rand_dst());
      seg_len = $urandom_range(20, 80);
      for (int i = 0; i < seg_len; i++) begin
        pending_frames.push_back(rand_frame());
        if (seg_idx == 0 && i == 0) hold_req++;
        if (seg_idx == 1 && i == seg_len / 2) wait_drained();
      end
      rand_done += seg_len;
      seg_idx++;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (expected_maps.size() != 0) begin
      $display("%0t: %0d results expected, got 0", $time, expected_maps.size());
      errors++;
    end
    if (errors == 0) begin
      $display("channel_downmix_mapper_top verification clean");
    end else begin
      $display("channel_downmix_mapper_top verification failed");
    end
    $finish;
  end

endmodule
